// File: sv/mts_pkg.sv
package mts_pkg;

    // Operation codes; code 3 behaves as peek
    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_PEEK   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] push_value;
    } req_t;

    typedef struct packed {
        logic signed [31:0] top_value;
        logic signed [31:0] min_value;
        logic [7:0]         entry_count;
        logic [1:0]         status;
    } rsp_t;

    // One stack slot: value and running minimum at or below it
    typedef struct packed {
        logic signed [31:0] value;
        logic signed [31:0] run_min;
    } entry_t;

endpackage

// File: sv/min_tracking_stack.sv
// Channel   Ports                       Dir  Payload
// request   s_valid s_ready s_data      in   mts_pkg::req_t (opcode, push_value)
// result    m_valid m_ready m_data      out  mts_pkg::rsp_t (top, min, count, status)
//
// Push, peek and refused ops need no memory read: the top slot is cached in registers.
// A pop that leaves entries goes through S_POP_READ: the new top comes from the slot
// memory, whose read port is registered.
// Reset (aresetn, sync, active low) empties the stack; memory is not cleared.
// A result waits in the output register; a new transaction is taken in the
// same cycle the pending result is taken.
module min_tracking_stack #(
    parameter int STACK_DEPTH = 128
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  mts_pkg::req_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output mts_pkg::rsp_t  m_data
);

    localparam int AW = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_POP_READ
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic signed [31:0] top_val_reg, top_val_next;
    logic signed [31:0] top_min_reg, top_min_next;
    logic               m_valid_reg, m_valid_next;
    mts_pkg::rsp_t      m_data_reg, m_data_next;

    logic               accept;
    logic               is_push;
    logic               is_pop;
    logic               full;
    logic               empty;
    logic signed [31:0] new_min;

    logic               wr_en;
    mts_pkg::entry_t    wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    mts_pkg::entry_t    rd_data;

    // Slot memory holds every entry; the top one is also mirrored in
    // top_val_reg/top_min_reg, so only a pop needs a read.
    mts_store #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (AW'(count_reg)),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_ready = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign is_push = (s_data.opcode == mts_pkg::OP_PUSH);
    assign is_pop  = (s_data.opcode == mts_pkg::OP_POP);
    assign full    = (count_reg == CW'(STACK_DEPTH));
    assign empty   = (count_reg == '0);

    // Running minimum of the new slot: signed compare with the min below
    assign new_min = (!empty && !(s_data.push_value < top_min_reg))
                     ? top_min_reg : s_data.push_value;

    assign wr_en   = accept && is_push && !full;
    assign wr_data = '{value: s_data.push_value, run_min: new_min};

    // Pop with two or more entries: fetch the slot that becomes the top.
    // Reads and writes never overlap: a pop holds off new transactions
    // until the read data is back.
    assign rd_en   = accept && is_pop && (count_reg > CW'(1));
    assign rd_addr = AW'(count_reg - CW'(2));

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        top_val_next = top_val_reg;
        top_min_next = top_min_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    m_data_next.status = mts_pkg::ST_OK;
                    if (is_push) begin
                        if (full) begin
                            m_data_next.status = mts_pkg::ST_OVERFLOW;
                        end else begin
                            count_next   = count_reg + CW'(1);
                            top_val_next = s_data.push_value;
                            top_min_next = new_min;
                        end
                    end else if (is_pop) begin
                        if (empty) begin
                            m_data_next.status = mts_pkg::ST_UNDERFLOW;
                        end else begin
                            count_next = count_reg - CW'(1);
                        end
                    end else if (empty) begin
                        // peek, and the unused code
                        m_data_next.status = mts_pkg::ST_UNDERFLOW;
                    end

                    m_data_next.entry_count = 8'(count_next);
                    if (count_next == '0) begin
                        m_data_next.top_value = '0;
                        m_data_next.min_value = '0;
                    end else begin
                        m_data_next.top_value = top_val_next;
                        m_data_next.min_value = top_min_next;
                    end

                    if (rd_en) begin
                        state_next = S_POP_READ;
                    end else begin
                        m_valid_next = 1'b1;
                    end
                end
            end
            S_POP_READ: begin
                top_val_next          = rd_data.value;
                top_min_next          = rd_data.run_min;
                m_data_next.top_value = rd_data.value;
                m_data_next.min_value = rd_data.run_min;
                m_valid_next          = 1'b1;
                state_next            = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        top_val_reg <= top_val_next;
        top_min_reg <= top_min_next;
        m_data_reg  <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Fill level stays within the stack
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // Output register is free while the pop read is in flight
    a_pop_read_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_POP_READ |-> !m_valid_reg)
        else $error("result pending during pop read");

    // A pop that leaves entries goes through the memory read
    a_pop_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && is_pop && count_reg > CW'(1)) |=> state_reg == S_POP_READ)
        else $error("pop skipped memory read");

    // No write lands while the read is outstanding
    a_no_write_in_read: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_POP_READ |-> !wr_en && !s_ready)
        else $error("write during pop read");

endmodule

// File: sv/mts_store.sv
module mts_store #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic               aclk,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  mts_pkg::entry_t    wr_data,
    input  logic               rd_en,
    input  logic [AW-1:0]      rd_addr,
    output mts_pkg::entry_t    rd_data
);

    mts_pkg::entry_t mem [DEPTH];
    mts_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
